### rtl/core/irot_pkg.sv
// Shared types and constants for the image rotate and interpolate core.
package irot_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned XBits     = $clog2(MaxWidth);
  localparam int unsigned YBits     = $clog2(MaxHeight);
  localparam int unsigned MemDepth  = MaxWidth * MaxHeight;
  localparam int unsigned AddrBits  = XBits + YBits;

  // Configuration register indexes
  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegCos    = 3'd2;
  localparam logic [2:0] RegSin    = 3'd3;
  localparam logic [2:0] RegMode   = 3'd4;

  // Commands
  localparam logic CmdWrite   = 1'b0;
  localparam logic CmdRequest = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] in_chan0;
    logic [7:0] in_chan1;
    logic [7:0] in_chan2;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
  } out_item_t;

endpackage

### rtl/core/image_rotate_interpolate_core.sv
// Image rotate core: frame store, inverse rotation mapping and pixel blend.
//
// Input channel (in_valid_i/in_stall_o/in_item_i) carries commands. A write
// command stores one source pixel in the frame memory in the cycle it is
// accepted if the point lies inside the frame (else it is dropped) and
// yields no result. A request command maps its point back through the
// configured rotation and returns one item on the output channel
// (out_valid_o/out_stall_i/out_item_o). A request is accepted, then runs:
// product stage, sum stage, coordinate stage, one frame memory read per
// cycle (1 read in nearest mode, 4 in bilinear mode), a drain state and a
// blend state; bilinear mode is slower for its three extra reads through
// the single frame memory read port. The input is stalled from acceptance
// until the result becomes valid, and the next item can be taken in that
// same cycle. The core takes the next item while a finished result
// waits in the output register; a request then waits in its blend cycle
// until that result is taken. Reset returns the registers to 256x256, no
// rotation, nearest mode; the frame memory is not cleared and must be
// written before it is read. Configuration is written over the APB port;
// the user must do so only while the core is idle, unenforced by the core.
module image_rotate_interpolate_core
  import irot_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PROD  = 7'b0000010,
    S_SUM   = 7'b0000100,
    S_COORD = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_BLEND = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [8:0]         width_q, height_q;
  logic signed [15:0] cos_q, sin_q;
  logic               mode_q;

  logic [8:0]  w_eff, h_eff;
  logic [15:0] cx, cy;

  logic [7:0] px_q, py_q;
  logic signed [18:0] dx, dy;
  logic signed [34:0] p_xc_q, p_ys_q, p_yc_q, p_xs_q;
  logic signed [35:0] sum_x, sum_y;
  logic signed [23:0] sx_q, sy_q, rnd, tx, ty;
  logic signed [15:0] xb_q, yb_q, xs, ys;
  logic [7:0]  fx_q, fy_q;
  logic [8:0]  gx, gy;

  logic [1:0]  cnt_q;
  logic        in_range;
  logic [AddrBits-1:0] rd_addr;
  logic [23:0] rd_q;
  logic        rd_in_q;
  logic [1:0]  rd_k_q;
  logic        rd_pend_q;
  logic [23:0] pix;

  logic [7:0]  lo_q [3];
  logic [15:0] v0_q [3];
  logic [15:0] v1_q [3];
  logic [15:0] vmix [3];
  logic [23:0] vout [3];
  logic [7:0]  res  [3];

  logic        out_valid_q;
  out_item_t   out_item_q;

  logic in_acc, out_acc, cfg_wr, wr_en, blend_go;

  logic [23:0] frame_mem [MemDepth];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      cos_q    <= 16'sd16384;
      sin_q    <= 16'sd0;
      mode_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegWidth:  width_q  <= pwdata[8:0];
        RegHeight: height_q <= pwdata[8:0];
        RegCos:    cos_q    <= pwdata[15:0];
        RegSin:    sin_q    <= pwdata[15:0];
        RegMode:   mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (paddr[4:2])
      RegWidth:  prdata = {23'b0, width_q};
      RegHeight: prdata = {23'b0, height_q};
      RegCos:    prdata = {{16{cos_q[15]}}, cos_q};
      RegSin:    prdata = {{16{sin_q[15]}}, sin_q};
      RegMode:   prdata = {31'b0, mode_q};
      default:   prdata = 32'b0;
    endcase
  end

  // Clamp dimensions and form frame center
  assign w_eff = (width_q > 9'(MaxWidth)) ? 9'(MaxWidth) : width_q;
  assign h_eff = (height_q > 9'(MaxHeight)) ? 9'(MaxHeight) : height_q;
  assign cx = {w_eff, 7'b0};
  assign cy = {h_eff, 7'b0};

  // Store source pixels inside the frame
  assign wr_en = in_acc && (in_item_i.command == CmdWrite) &&
                 ({1'b0, in_item_i.pos_x} < w_eff) &&
                 ({1'b0, in_item_i.pos_y} < h_eff);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[{in_item_i.pos_y, in_item_i.pos_x}] <= {in_item_i.in_chan2,
                                                       in_item_i.in_chan1,
                                                       in_item_i.in_chan0};
    end
    rd_q <= frame_mem[rd_addr];
  end

  // Offsets from center and rotated sums
  assign dx = $signed({3'b0, px_q, 8'b0}) - $signed({3'b0, cx});
  assign dy = $signed({3'b0, cy}) - $signed({3'b0, py_q, 8'b0});
  assign sum_x = 36'(p_xc_q) + 36'(p_ys_q);
  assign sum_y = 36'(p_yc_q) - 36'(p_xs_q);
  assign rnd = mode_q ? 24'sd0 : 24'sd128;
  assign tx = sx_q + rnd;
  assign ty = sy_q + rnd;

  // Neighbor coordinate and bounds for the current read
  assign xs = xb_q + {15'b0, cnt_q[1]};
  assign ys = yb_q + {15'b0, cnt_q[0]};
  assign in_range = !xs[15] && !ys[15] && (xs < {7'b0, w_eff}) && (ys < {7'b0, h_eff});
  assign rd_addr = {ys[YBits-1:0], xs[XBits-1:0]};
  assign pix = rd_in_q ? rd_q : 24'b0;

  assign gx = 9'd256 - {1'b0, fx_q};
  assign gy = 9'd256 - {1'b0, fy_q};

  // Blend per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vmix[c] = 16'(lo_q[c] * gy + pix[8*c +: 8] * fy_q);
      vout[c] = 24'(v0_q[c] * gx + v1_q[c] * fx_q);
      res[c]  = mode_q ? vout[c][23:16] : lo_q[c];
    end
  end

  assign blend_go = (state_q == S_BLEND) && (!out_valid_q || out_acc);

  // Sequence one request
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc && in_item_i.command == CmdRequest) state_d = S_PROD;
      S_PROD:  state_d = S_SUM;
      S_SUM:   state_d = S_COORD;
      S_COORD: state_d = S_FETCH;
      S_FETCH: if (!mode_q || cnt_q == 2'd3) state_d = S_DRAIN;
      S_DRAIN: state_d = S_BLEND;
      S_BLEND: if (blend_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 2'd0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == S_FETCH);
      if (state_q == S_FETCH) cnt_q <= cnt_q + 2'd1;
      else cnt_q <= 2'd0;
      if (blend_go) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= in_item_i.pos_x;
      py_q <= in_item_i.pos_y;
    end
    if (state_q == S_PROD) begin
      p_xc_q <= dx * cos_q;
      p_ys_q <= dy * sin_q;
      p_yc_q <= dy * cos_q;
      p_xs_q <= dx * sin_q;
    end
    if (state_q == S_SUM) begin
      sx_q <= {{2{sum_x[35]}}, sum_x[35:14]} + $signed({8'b0, cx});
      sy_q <= $signed({8'b0, cy}) - {{2{sum_y[35]}}, sum_y[35:14]};
    end
    if (state_q == S_COORD) begin
      xb_q <= tx[23:8];
      yb_q <= ty[23:8];
      fx_q <= sx_q[7:0];
      fy_q <= sy_q[7:0];
    end
    rd_in_q <= in_range;
    rd_k_q  <= cnt_q;
    if (rd_pend_q) begin
      for (int c = 0; c < 3; c++) begin
        case (rd_k_q)
          2'd0, 2'd2: lo_q[c] <= pix[8*c +: 8];
          2'd1:       v0_q[c] <= vmix[c];
          default:    v1_q[c] <= vmix[c];
        endcase
      end
    end
    if (blend_go) begin
      out_item_q.out_chan0 <= res[0];
      out_item_q.out_chan1 <= res[1];
      out_item_q.out_chan2 <= res[2];
    end
  end

`ifndef SYNTHESIS
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_nearest_one_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH && !mode_q) |-> cnt_q == 2'd0)
    else $error("nearest mode issued extra read");
  a_result_from_blend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_BLEND))
    else $error("result raised outside blend");
  a_write_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.command == CmdWrite) |=> state_q == S_IDLE)
    else $error("write command left idle");
`endif

endmodule
